// ===== rtl/fxalu_pkg.sv =====
`timescale 1ns / 1ps
package fxalu_pkg;

   localparam int WORD_W = 32;

   typedef enum logic [3:0] {
      CMD_ADD = 4'd0, CMD_SUB = 4'd1, CMD_MUL = 4'd2, CMD_DIV = 4'd3,
      CMD_GT = 4'd4, CMD_LT = 4'd5, CMD_GE = 4'd6, CMD_LE = 4'd7,
      CMD_EQ = 4'd8, CMD_NE = 4'd9, CMD_MIN = 4'd10, CMD_MAX = 4'd11,
      CMD_INC = 4'd12, CMD_DEC = 4'd13, CMD_FROM_INT = 4'd14, CMD_TO_INT = 4'd15
   } cmd_type;

   typedef struct packed {
      logic [3:0]               cmd;
      logic signed [WORD_W-1:0] lhs_raw;
      logic signed [WORD_W-1:0] rhs_raw;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] result_raw;
      logic                     compare_true;
      logic                     divide_by_zero;
   } rsp_type;

endpackage

// ===== rtl/fxalu_div_cell.sv =====
`timescale 1ns / 1ps
module fxalu_div_cell #(
   parameter int QW = 40,
   parameter int DW = 32,
   parameter int CW = 47
) (
   input  logic          clock,
   input  logic          advance,
   input  logic [DW:0]   rem_in,
   input  logic [QW-1:0] num_in,
   input  logic [DW-1:0] den_in,
   input  logic [CW-1:0] ctx_in,
   output logic [DW:0]   rem_out,
   output logic [QW-1:0] num_out,
   output logic [DW-1:0] den_out,
   output logic [CW-1:0] ctx_out
);
   // One restoring-division step: shift in the next numerator bit, subtract
   // when the partial remainder covers the divisor. Quotient bits replace
   // numerator bits from the bottom as the numerator shifts out the top.
   logic [DW+1:0] trial;
   logic [DW+1:0] sub;
   logic [DW:0]   rem_ff, rem_in_w;
   logic [QW-1:0] num_ff, num_in_w;
   logic [DW-1:0] den_ff;
   logic [CW-1:0] ctx_ff;

   always_comb begin
      trial = {rem_in, num_in[QW-1]};
      sub   = trial - {2'b00, den_in};
      if (!sub[DW+1]) begin
         rem_in_w = sub[DW:0];
         num_in_w = {num_in[QW-2:0], 1'b1};
      end else begin
         rem_in_w = trial[DW:0];
         num_in_w = {num_in[QW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff <= rem_in_w;
         num_ff <= num_in_w;
         den_ff <= den_in;
         ctx_ff <= ctx_in;
      end
   end

   assign rem_out = rem_ff;
   assign num_out = num_ff;
   assign den_out = den_ff;
   assign ctx_out = ctx_ff;
endmodule

// ===== rtl/fixed_point_q24_8_alu_unit.sv =====
`timescale 1ns / 1ps
// Signed fixed-point ALU, one request per cycle while rsp_stall is low. Every
// operation runs down a fixed pipeline of 32+FRAC_BITS+3 stages, set by the
// chain of restoring-division cells (one quotient bit per cell). Multiply is
// computed at the head in two registered steps and rides the chain with the
// other results. rsp_stall freezes the whole chain; req_stall mirrors it.
module fixed_point_q24_8_alu_unit #(
   parameter int FRAC_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  fxalu_pkg::req_type   req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output fxalu_pkg::rsp_type   rsp_data
);
   import fxalu_pkg::*;

   localparam int W    = WORD_W;
   localparam int QW   = W + FRAC_BITS;
   localparam int CW   = W + 4;
   localparam int LAT  = QW + 3;

   logic advance;
   assign advance   = !rsp_stall;
   assign req_stall = rsp_stall;

   // valid shift line
   logic [LAT-1:0] vld_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end

   // Stage 0: register request, magnitudes and sign; simple results follow combinationally.
   logic [3:0]      s0_cmd_ff;
   logic signed [W-1:0] s0_a_ff, s0_b_ff;
   logic [W-1:0]    s0_ma_ff, s0_mb_ff;
   logic            s0_neg_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         s0_cmd_ff <= req_data.cmd;
         s0_a_ff   <= req_data.lhs_raw;
         s0_b_ff   <= req_data.rhs_raw;
         s0_ma_ff  <= req_data.lhs_raw[W-1] ? W'(-req_data.lhs_raw) : req_data.lhs_raw;
         s0_mb_ff  <= req_data.rhs_raw[W-1] ? W'(-req_data.rhs_raw) : req_data.rhs_raw;
         s0_neg_ff <= req_data.lhs_raw[W-1] ^ req_data.rhs_raw[W-1];
      end
   end

   logic [W-1:0] simple_res;
   logic         simple_cmp;
   always_comb begin
      simple_res = '0;
      simple_cmp = 1'b0;
      case (s0_cmd_ff)
         CMD_ADD:      simple_res = W'(s0_a_ff + s0_b_ff);
         CMD_SUB:      simple_res = W'(s0_a_ff - s0_b_ff);
         CMD_GT:       simple_cmp = s0_a_ff > s0_b_ff;
         CMD_LT:       simple_cmp = s0_a_ff < s0_b_ff;
         CMD_GE:       simple_cmp = s0_a_ff >= s0_b_ff;
         CMD_LE:       simple_cmp = s0_a_ff <= s0_b_ff;
         CMD_EQ:       simple_cmp = s0_a_ff == s0_b_ff;
         CMD_NE:       simple_cmp = s0_a_ff != s0_b_ff;
         CMD_MIN:      simple_res = (s0_a_ff < s0_b_ff) ? s0_a_ff : s0_b_ff;
         CMD_MAX:      simple_res = (s0_a_ff > s0_b_ff) ? s0_a_ff : s0_b_ff;
         CMD_INC:      simple_res = W'(s0_a_ff + 1);
         CMD_DEC:      simple_res = W'(s0_a_ff - 1);
         CMD_FROM_INT: simple_res = W'(s0_a_ff <<< FRAC_BITS);
         CMD_TO_INT:   simple_res = W'(s0_a_ff >>> FRAC_BITS);
         default:      simple_res = '0;
      endcase
   end

   // Stage 1: raw product of magnitudes; stage 2: round and saturate.
   logic [2*W-1:0] s1_prod_ff;
   logic [3:0]     s1_cmd_ff;
   logic [W-1:0]   s1_res_ff;
   logic           s1_cmp_ff, s1_neg_ff;
   logic [QW-1:0]  s1_num_ff;
   logic [W-1:0]   s1_den_ff;
   logic           s1_dz_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_prod_ff <= s0_ma_ff * s0_mb_ff;
         s1_cmd_ff  <= s0_cmd_ff;
         s1_res_ff  <= simple_res;
         s1_cmp_ff  <= simple_cmp;
         s1_neg_ff  <= s0_neg_ff;
         s1_num_ff  <= {s0_ma_ff, FRAC_BITS'(0)};
         s1_den_ff  <= s0_mb_ff;
         s1_dz_ff   <= (s0_cmd_ff == CMD_DIV) && (s0_b_ff == '0);
      end
   end

   // Saturation of a rounded magnitude with a sign.
   function automatic logic [W-1:0] sat_sign(input logic [QW:0] mag, input logic neg);
      logic [QW:0] lim;
      lim = neg ? (QW+1)'({1'b1, {(W-1){1'b0}}}) : (QW+1)'({1'b0, {(W-1){1'b1}}});
      if (mag > lim) return neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      return neg ? W'(-mag) : W'(mag);
   endfunction

   logic [2*W-FRAC_BITS:0] mul_rnd;
   logic [W-1:0]           mul_res;
   always_comb begin
      mul_rnd = (2*W-FRAC_BITS+1)'(({1'b0, s1_prod_ff} + (2*W+1)'(1 << (FRAC_BITS-1)))
                                    >> FRAC_BITS);
      if (mul_rnd > (2*W-FRAC_BITS+1)'({1'b1, {(W-1){1'b0}}}) ||
          (!s1_neg_ff && mul_rnd[W-1 +: (2*W-FRAC_BITS+1-(W-1))] != '0))
         mul_res = s1_neg_ff ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      else
         mul_res = s1_neg_ff ? W'(-mul_rnd) : W'(mul_rnd);
   end

   // Context carried beside the division chain: result, cmp, dz, is_div, neg.
   logic [CW-1:0] ctx_head;
   assign ctx_head = {(s1_cmd_ff == CMD_MUL) ? mul_res : s1_res_ff,
                      s1_cmp_ff, s1_dz_ff,
                      (s1_cmd_ff == CMD_DIV) && !s1_dz_ff, s1_neg_ff};

   logic [W:0]    rem_c [QW+1];
   logic [QW-1:0] num_c [QW+1];
   logic [W-1:0]  den_c [QW+1];
   logic [CW-1:0] ctx_c [QW+1];
   assign rem_c[0] = '0;
   assign num_c[0] = s1_num_ff;
   assign den_c[0] = s1_den_ff;
   assign ctx_c[0] = ctx_head;

   for (genvar g = 0; g < QW; g++) begin : g_cell
      fxalu_div_cell #(.QW(QW), .DW(W), .CW(CW)) u_cell (
         .clock, .advance,
         .rem_in(rem_c[g]), .num_in(num_c[g]), .den_in(den_c[g]), .ctx_in(ctx_c[g]),
         .rem_out(rem_c[g+1]), .num_out(num_c[g+1]),
         .den_out(den_c[g+1]), .ctx_out(ctx_c[g+1])
      );
   end

   // Final stage: round half up on remainder, saturate, select.
   logic [W:0]    last_rem;
   logic [QW-1:0] last_q;
   logic [CW-1:0] last_ctx;
   logic [W-1:0]  div_res;
   logic          rnd_up;
   assign last_rem = rem_c[QW];
   assign last_q   = num_c[QW];
   assign last_ctx = ctx_c[QW];
   assign rnd_up   = last_rem >= ({1'b0, den_c[QW]} - last_rem);
   always_comb begin
      div_res = sat_sign((QW+1)'(last_q) + (QW+1)'(rnd_up), last_ctx[0]);
   end

   rsp_type out_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff.result_raw     <= last_ctx[1] ? div_res : last_ctx[CW-1 -: W];
         out_ff.compare_true   <= last_ctx[3];
         out_ff.divide_by_zero <= last_ctx[2];
      end
   end

   assign rsp_valid = vld_ff[LAT-1];
   assign rsp_data  = out_ff;

`ifndef SYNTHESIS
   a_dz_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.divide_by_zero |-> rsp_data.result_raw == '0
                                            && !rsp_data.compare_true)
      else $error("divide by zero with nonzero result");
   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      rsp_stall |=> vld_ff == $past(vld_ff))
      else $error("pipeline moved under stall");
`endif
endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
module tb;
   import fxalu_pkg::*;

   localparam int FRAC = 8;
   localparam int PIPE_DEPTH = 44;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 1250;
   localparam int QUIET_TAIL = 150;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   bit      fill_done;
   bit      req_taken;
   int      req_gap;
   int      stall_gap;
   int      cycle_count;
   int      error_count;
   int      reqs_sent;
   int      rsps_checked;
   int      div_zero_seen;
   int      saturations_seen;

   fixed_point_q24_8_alu_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   // Exact Q24.8 arithmetic: multiply and divide round half away from zero,
   // then saturate; everything else wraps to 32 bits.
   function automatic rsp_type alu_predict(req_type r);
      rsp_type          o;
      logic signed [31:0] a, b;
      logic [63:0]      ma, mb, mag, q, rm, lim;
      logic             neg;
      a = r.lhs_raw;
      b = r.rhs_raw;
      o = '0;
      neg = a[31] ^ b[31];
      ma = a[31] ? 64'(-longint'(a)) : 64'(a);
      mb = b[31] ? 64'(-longint'(b)) : 64'(b);
      lim = neg ? 64'h8000_0000 : 64'h7fff_ffff;
      case (cmd_type'(r.cmd))
         CMD_ADD: o.result_raw = a + b;
         CMD_SUB: o.result_raw = a - b;
         CMD_MUL: begin
            mag = ((ma * mb) + 64'(1 << (FRAC - 1))) >> FRAC;
            o.result_raw = (mag > lim) ? lim[31:0] : (neg ? 32'(-mag) : mag[31:0]);
         end
         CMD_DIV: begin
            if (b == 0) begin
               o.divide_by_zero = 1'b1;
            end else begin
               q = (ma << FRAC) / mb;
               rm = (ma << FRAC) % mb;
               if (rm >= mb - rm) q = q + 1;
               o.result_raw = (q > lim) ? lim[31:0] : (neg ? 32'(-q) : q[31:0]);
            end
         end
         CMD_GT: o.compare_true = a > b;
         CMD_LT: o.compare_true = a < b;
         CMD_GE: o.compare_true = a >= b;
         CMD_LE: o.compare_true = a <= b;
         CMD_EQ: o.compare_true = a == b;
         CMD_NE: o.compare_true = a != b;
         CMD_MIN: o.result_raw = (a < b) ? a : b;
         CMD_MAX: o.result_raw = (a > b) ? a : b;
         CMD_INC: o.result_raw = a + 1;
         CMD_DEC: o.result_raw = a - 1;
         CMD_FROM_INT: o.result_raw = a << FRAC;
         default: o.result_raw = a >>> FRAC;
      endcase
      return o;
   endfunction

   function automatic logic [31:0] pick_operand();
      logic [31:0] v;
      case ($urandom_range(0, 9))
         0: v = 32'h8000_0000;
         1: v = 32'h7fff_ffff;
         2: v = 32'($urandom_range(0, 4)) - 32'd2;
         3: v = 32'($urandom_range(0, 4096)) - 32'd2048;
         4: v = 32'($urandom_range(0, 1 << 20)) - 32'd524288;
         default: v = $urandom;
      endcase
      return v;
   endfunction

   task automatic queue_req(cmd_type c, logic [31:0] a, logic [31:0] b);
      req_type r;
      r.cmd = c;
      r.lhs_raw = a;
      r.rhs_raw = b;
      pending_reqs.push_back(r);
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   initial begin
      int c;
      for (c = 0; c < 16; c++) queue_req(cmd_type'(c), 32'h0000_0300, 32'hffff_fe80);
      queue_req(CMD_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
      queue_req(CMD_MUL, 32'h8000_0000, 32'h8000_0000);
      queue_req(CMD_MUL, 32'h8000_0000, 32'h7fff_ffff);
      queue_req(CMD_MUL, 32'h0000_0001, 32'h0000_0080);
      queue_req(CMD_MUL, 32'hffff_ffff, 32'h0000_0080);
      queue_req(CMD_DIV, 32'h7fff_ffff, 32'h0000_0000);
      queue_req(CMD_DIV, 32'h8000_0000, 32'h0000_0001);
      queue_req(CMD_DIV, 32'h0000_0001, 32'h0000_0200);
      queue_req(CMD_ADD, 32'h7fff_ffff, 32'h0000_0001);
      queue_req(CMD_TO_INT, 32'h8000_0000, 32'h0);
      for (c = 0; c < RANDOM_ITEMS; c++)
         queue_req(cmd_type'($urandom_range(0, 15)), pick_operand(), pick_operand());
      fill_done = 1'b1;
   end

   // Request driver: a new request goes out once the previous one was taken.
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (req_gap == 0 && pending_reqs.size() > QUIET_TAIL && $urandom_range(0, 9) == 0)
            req_gap = $urandom_range(1, 12);
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            req_data <= pending_reqs.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (stall_gap > 0) begin
            stall_gap--;
            rsp_stall <= 1'b1;
         end else if (pending_reqs.size() > QUIET_TAIL && $urandom_range(0, 9) == 0) begin
            stall_gap = $urandom_range(0, 11);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_type exp_rsp;
      cycle_count <= cycle_count + 1;
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response %h", $time, rsp_data);
            error_count++;
         end else begin
            exp_rsp = expected_rsps.pop_front();
            rsps_checked++;
            if (rsp_data.result_raw != exp_rsp.result_raw) begin
               $display("%0t: result_raw expected %h actual %h", $time,
                        exp_rsp.result_raw, rsp_data.result_raw);
               error_count++;
            end
            if (rsp_data.compare_true != exp_rsp.compare_true) begin
               $display("%0t: compare_true expected %b actual %b", $time,
                        exp_rsp.compare_true, rsp_data.compare_true);
               error_count++;
            end
            if (rsp_data.divide_by_zero != exp_rsp.divide_by_zero) begin
               $display("%0t: divide_by_zero expected %b actual %b", $time,
                        exp_rsp.divide_by_zero, rsp_data.divide_by_zero);
               error_count++;
            end
         end
      end
      if (!reset && req_valid && !req_stall) begin
         exp_rsp = alu_predict(req_data);
         if (exp_rsp.divide_by_zero) div_zero_seen++;
         if ((req_data.cmd == CMD_MUL || req_data.cmd == CMD_DIV) &&
             (exp_rsp.result_raw == 32'h7fff_ffff || exp_rsp.result_raw == 32'h8000_0000))
            saturations_seen++;
         expected_rsps.push_back(exp_rsp);
         reqs_sent++;
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      wait (fill_done);
      @(posedge clock);
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (PIPE_DEPTH + 10) @(posedge clock);
      $display("Sent %0d requests over all 16 operations, checked %0d responses.",
               reqs_sent, rsps_checked);
      $display("Covered %0d divides by zero and %0d saturated multiply/divide results.",
               div_zero_seen, saturations_seen);
      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
